// ----- src/ncsm_pkg.sv -----
package ncsm_pkg;

  localparam int VALUE_W          = 24;
  localparam int CHI_W            = 32;
  localparam int STATUS_W         = 3;
  localparam int QUOT_W           = CHI_W + 1;
  localparam int MAX_CHANNELS_DEF = 32;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_HYP_ZERO  = 3'd1,
    STS_SIG_ZERO  = 3'd2,
    STS_SATURATED = 3'd3,
    STS_DROPPED   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CHECK,
    S_HS,
    S_RD,
    S_A,
    S_B,
    S_DIFF,
    S_SQ0,
    S_SQ1,
    S_SQ2,
    S_DEN0,
    S_DEN1,
    S_GO,
    S_DIV,
    S_ACC,
    S_OUT
  } state_t;

endpackage

// ----- src/normalized_chi2_shape_match_core.sv -----
// Normalized chi-square shape match. Channel words (signal, hypothesis) are
// taken one per cycle and stored in a single-port-write RAM while running
// totals S and H build up; the word with tlast closes the set. The block then
// walks the stored channels and emits one result word: sum over h != 0 of
// floor((S*h - s*H)^2 / (H*S*h)), saturating at 2^32-1, with a status code.
// While the set is processed in_tready is low. Closing walks the stored
// channels in turn: a channel whose hypothesis is zero is skipped after its
// RAM read; any other goes through the shared multiplier (cross products,
// squaring and the denominator in partial products) and then the bit-serial
// divider that yields 33 quotient bits. A result waiting in the output
// register does not block loading of the next set.
module normalized_chi2_shape_match_core #(
  parameter int MAX_CHANNELS = ncsm_pkg::MAX_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // signal_value[23:0], hypothesis_value[47:24]
  input  logic        in_tlast,   // last_channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // chi_square[31:0]
  output logic [2:0]  out_tuser   // status[2:0]
);

  import ncsm_pkg::*;

  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int TW = VALUE_W + CW;
  localparam int DW = TW + VALUE_W;
  localparam int HW = (DW + 1) / 2;
  localparam int OW = (TW > HW) ? TW : HW;
  localparam int PW = 2 * OW;
  localparam int NW = 2 * DW;
  localparam int EW = 2 * TW + VALUE_W;

  state_t state_r, state_nxt;

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      idx_r;
  logic [TW-1:0]      stot_r;
  logic [TW-1:0]      htot_r;
  logic               ovf_r;
  logic [CHI_W-1:0]   chi_r;
  status_t            sts_r;
  logic               out_valid_r;
  logic [CHI_W-1:0]   out_chi_r;
  status_t            out_sts_r;

  logic [VALUE_W-1:0] s_r, h_r;
  logic [DW-1:0]      a_r, b_r, diff_r;
  logic [NW-1:0]      num_r;
  logic [EW-1:0]      den_r;
  logic [2*TW-1:0]    hs_r;

  logic [OW-1:0]      mul_a, mul_b;
  logic [PW-1:0]      prod;

  logic                 in_acc, we, rd_en, div_start, div_done, out_free, last_chan, sat;
  logic [2*VALUE_W-1:0] rd_data;
  logic [VALUE_W-1:0]   rd_s, rd_h;
  logic [QUOT_W-1:0]    div_q;
  logic [CHI_W:0]       acc_sum;

  assign in_acc    = in_tvalid && in_tready;
  assign we        = in_acc && (count_r < CW'(MAX_CHANNELS));
  assign out_free  = !out_valid_r || out_tready;
  assign last_chan = ((idx_r + CW'(1)) == count_r);
  assign rd_s      = rd_data[VALUE_W-1:0];
  assign rd_h      = rd_data[2*VALUE_W-1:VALUE_W];
  assign acc_sum   = {1'b0, chi_r} + {1'b0, div_q[CHI_W-1:0]};
  assign sat       = div_q[QUOT_W-1] || acc_sum[CHI_W];

  ncsm_ram #(
    .WIDTH(2 * VALUE_W),
    .DEPTH(MAX_CHANNELS),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(count_r[AW-1:0]),
    .wdata(in_tdata[2*VALUE_W-1:0]),
    .re   (rd_en),
    .raddr(idx_r[AW-1:0]),
    .rdata(rd_data)
  );

  ncsm_div #(
    .NW(NW),
    .EW(EW),
    .QW(QUOT_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (num_r),
    .den  (den_r),
    .done (div_done),
    .quot (div_q)
  );

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_HS:    begin mul_a = OW'(htot_r);              mul_b = OW'(stot_r); end
      S_A:     begin mul_a = OW'(stot_r);              mul_b = OW'(rd_h); end
      S_B:     begin mul_a = OW'(s_r);                 mul_b = OW'(htot_r); end
      S_SQ0:   begin mul_a = OW'(diff_r[HW-1:0]);      mul_b = OW'(diff_r[HW-1:0]); end
      S_SQ1:   begin mul_a = OW'(diff_r[HW-1:0]);      mul_b = OW'(diff_r[DW-1:HW]); end
      S_SQ2:   begin mul_a = OW'(diff_r[DW-1:HW]);     mul_b = OW'(diff_r[DW-1:HW]); end
      S_DEN0:  begin mul_a = OW'(hs_r[TW-1:0]);        mul_b = OW'(h_r); end
      S_DEN1:  begin mul_a = OW'(hs_r[2*TW-1:TW]);     mul_b = OW'(h_r); end
      default: begin mul_a = '0;                       mul_b = '0; end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:  if (in_acc && in_tlast) state_nxt = S_CHECK;
      S_CHECK: state_nxt = (htot_r == '0 || stot_r == '0) ? S_OUT : S_HS;
      S_HS:    state_nxt = S_RD;
      S_RD:    state_nxt = S_A;
      S_A:     begin
        if (rd_h != '0) state_nxt = S_B;
        else            state_nxt = last_chan ? S_OUT : S_RD;
      end
      S_B:     state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_SQ0;
      S_SQ0:   state_nxt = S_SQ1;
      S_SQ1:   state_nxt = S_SQ2;
      S_SQ2:   state_nxt = S_DEN0;
      S_DEN0:  state_nxt = S_DEN1;
      S_DEN1:  state_nxt = S_GO;
      S_GO:    state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_ACC;
      S_ACC:   state_nxt = (sat || last_chan) ? S_OUT : S_RD;
      S_OUT:   if (out_free) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    in_tready = (state_r == S_LOAD);
    rd_en     = (state_r == S_RD);
    div_start = (state_r == S_GO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      idx_r       <= '0;
      stot_r      <= '0;
      htot_r      <= '0;
      ovf_r       <= 1'b0;
      chi_r       <= '0;
      sts_r       <= STS_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (we) begin
          count_r <= count_r + CW'(1);
          stot_r  <= stot_r + TW'(in_tdata[VALUE_W-1:0]);
          htot_r  <= htot_r + TW'(in_tdata[2*VALUE_W-1:VALUE_W]);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CHECK: begin
          chi_r <= '0;
          idx_r <= '0;
          if (htot_r == '0)      sts_r <= STS_HYP_ZERO;
          else if (stot_r == '0) sts_r <= STS_SIG_ZERO;
          else if (ovf_r)        sts_r <= STS_DROPPED;
          else                   sts_r <= STS_OK;
        end
        S_A: begin
          if (rd_h == '0) idx_r <= idx_r + CW'(1);
        end
        S_ACC: begin
          if (sat) begin
            chi_r <= '1;
            sts_r <= STS_SATURATED;
          end else begin
            chi_r <= acc_sum[CHI_W-1:0];
            idx_r <= idx_r + CW'(1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            count_r     <= '0;
            stot_r      <= '0;
            htot_r      <= '0;
            ovf_r       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_HS:    hs_r <= prod[2*TW-1:0];
      S_A:     begin
        s_r <= rd_s;
        h_r <= rd_h;
        a_r <= prod[DW-1:0];
      end
      S_B:     b_r <= prod[DW-1:0];
      S_DIFF:  diff_r <= (a_r >= b_r) ? (a_r - b_r) : (b_r - a_r);
      S_SQ0:   num_r <= NW'(prod);
      S_SQ1:   num_r <= num_r + (NW'(prod) << (HW + 1));
      S_SQ2:   num_r <= num_r + (NW'(prod) << (2 * HW));
      S_DEN0:  den_r <= EW'(prod);
      S_DEN1:  den_r <= den_r + (EW'(prod) << TW);
      S_OUT:   begin
        if (out_free) begin
          out_chi_r <= chi_r;
          out_sts_r <= sts_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_chi_r;
  assign out_tuser  = out_sts_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> idx_r < count_r)
    else $error("read of a channel beyond the stored set");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> !in_tready)
    else $error("input taken while a set is being closed");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == STS_SATURATED) |-> out_tdata == '1)
    else $error("saturated status without full-scale word");

endmodule

// ----- src/ncsm_ram.sv -----
module ncsm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/ncsm_div.sv -----
module ncsm_div #(
  parameter int NW = 108,
  parameter int EW = 84,
  parameter int QW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [EW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quot
);

  localparam int RW    = EW + QW;
  localparam int CNT_W = $clog2(QW + 1);

  logic [RW-1:0]    rem_r;
  logic [RW-1:0]    dsh_r;
  logic [QW-1:0]    q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             take;

  assign take = (rem_r >= dsh_r);

  // restoring division, one quotient bit per cycle, top bit first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= RW'(num);
      dsh_r <= RW'(den) << (QW - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      if (take) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[QW-2:0], take};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
